>>> sv/sqal_pkg.sv
// Shared types and constants for the quote-aware command-line lexer.
// Depends on nothing; every other file of the block imports it.
package sqal_pkg;

    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef enum logic [1:0] {
        KIND_WORD   = 2'd0,
        KIND_IN     = 2'd1,
        KIND_OUT    = 2'd2,
        KIND_APPEND = 2'd3
    } token_kind_t;

    // Lexer mode, one-hot.
    typedef enum logic [4:0] {
        MODE_OUT  = 5'b00001,
        MODE_WORD = 5'b00010,
        MODE_DQ   = 5'b00100,
        MODE_ESC  = 5'b01000,
        MODE_SQ   = 5'b10000
    } lex_mode_t;

    // Lexer state carried from one byte to the next.
    typedef struct packed {
        lex_mode_t mode;
        logic      gt_pending;
    } lex_state_t;

    // Tags produced for one byte.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        keep;
        logic        token_start;
        token_kind_t token_kind;
        logic        quoted;
        logic        unclosed_quote;
    } lex_result_t;

endpackage

>>> sv/sqal_step.sv
// Combinational lexer step: tags one byte and computes the next lexer state.
// Depends on sqal_pkg.
module sqal_step
    import sqal_pkg::*;
(
    input  logic [7:0]  in_byte,
    input  logic        line_end,
    input  lex_state_t  state_cur,
    output lex_state_t  state_next,
    output lex_result_t result
);

    lex_mode_t   mode_next;
    logic        pend_next;
    logic        keep;
    logic        start;
    token_kind_t kind;
    logic        quoted;
    logic        unclosed;

    always_comb begin
        mode_next = state_cur.mode;
        pend_next = 1'b0;
        keep      = 1'b1;
        start     = 1'b0;
        kind      = KIND_WORD;
        quoted    = 1'b0;
        unclosed  = 1'b0;

        case (state_cur.mode)
            MODE_DQ: begin
                quoted = 1'b1;
                if (in_byte == CH_DQUOTE) begin
                    mode_next = MODE_WORD;
                end else if (in_byte == CH_BACKSLASH) begin
                    mode_next = MODE_ESC;
                end
            end
            MODE_ESC: begin
                quoted    = 1'b1;
                mode_next = MODE_DQ;
            end
            MODE_SQ: begin
                quoted = 1'b1;
                if (in_byte == CH_SQUOTE) begin
                    mode_next = MODE_WORD;
                end
            end
            default: begin
                // Outside a token or in the unquoted part of a word.
                if (in_byte == CH_SPACE) begin
                    keep      = 1'b0;
                    mode_next = MODE_OUT;
                end else if (in_byte == CH_GT) begin
                    if (state_cur.gt_pending) begin
                        kind = KIND_APPEND;
                    end else begin
                        kind      = KIND_OUT;
                        start     = 1'b1;
                        pend_next = 1'b1;
                    end
                    mode_next = MODE_OUT;
                end else if (in_byte == CH_LT) begin
                    kind      = KIND_IN;
                    start     = 1'b1;
                    mode_next = MODE_OUT;
                end else begin
                    start = (state_cur.mode != MODE_WORD);
                    if (in_byte == CH_DQUOTE) begin
                        quoted    = 1'b1;
                        mode_next = MODE_DQ;
                    end else if (in_byte == CH_SQUOTE) begin
                        quoted    = 1'b1;
                        mode_next = MODE_SQ;
                    end else begin
                        mode_next = MODE_WORD;
                    end
                end
            end
        endcase

        if (line_end) begin
            unclosed  = (mode_next == MODE_DQ) || (mode_next == MODE_ESC)
                        || (mode_next == MODE_SQ);
            mode_next = MODE_OUT;
            pend_next = 1'b0;
        end
    end

    assign state_next.mode       = mode_next;
    assign state_next.gt_pending = pend_next;

    assign result.out_byte       = in_byte;
    assign result.keep           = keep;
    assign result.token_start    = start;
    assign result.token_kind     = kind;
    assign result.quoted         = quoted;
    assign result.unclosed_quote = unclosed;

endmodule

>>> sv/shell_quote_aware_lexer_core.sv
// Top level of the quote-aware command-line lexer.
// Depends on sqal_pkg and sqal_step.
//
// Usage: one command-line byte enters per transfer on the s_ channel
// (s_in_byte, plus s_line_end on the final byte of a line). For every byte
// exactly one tagged result leaves on the m_ channel: the byte echoed, a keep
// flag (0 for a separating space), a token-start flag, the token kind, a
// quoted flag and, on the final byte of a line, an unclosed-quote flag.
// Each byte is captured in an input register, tagged by the lexer step logic
// against the lexer state register, and captured in the result register.
// Throughput is one byte per cycle while the receiver does not stall; the
// lexer state update is the one recurrence.
// Synchronous active-low reset empties both registers and returns the lexer
// to the outside-any-token state. When the receiver stalls, the result
// register holds its transfer and the input register can still take one more
// byte; after that s_ready drops until the result is taken.
module shell_quote_aware_lexer_core
    import sqal_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_line_end,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_keep,
    output logic       m_token_start,
    output logic [1:0] m_token_kind,
    output logic       m_quoted,
    output logic       m_unclosed_quote
);

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_line_end_reg;

    // Lexer state.
    lex_state_t  state_reg;
    lex_state_t  state_next;

    // Result register.
    logic        out_valid_reg;
    lex_result_t out_reg;
    lex_result_t step_result;

    logic        advance;
    logic        in_take;

    // The held byte moves into the result register when the result slot is
    // empty or its transfer completes in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    sqal_step u_step (
        .in_byte    (in_byte_reg),
        .line_end   (in_line_end_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            state_reg.mode       <= MODE_OUT;
            state_reg.gt_pending <= 1'b0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg     <= s_in_byte;
            in_line_end_reg <= s_line_end;
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_out_byte       = out_reg.out_byte;
    assign m_keep           = out_reg.keep;
    assign m_token_start    = out_reg.token_start;
    assign m_token_kind     = out_reg.token_kind;
    assign m_quoted         = out_reg.quoted;
    assign m_unclosed_quote = out_reg.unclosed_quote;

endmodule
